// File: design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds in this cycle, consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// checked also while reset is high
`define ASSERT_NEXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/nmea_cc_pkg.sv
package nmea_cc_pkg;

  localparam int IN_W  = 8;
  localparam int OUT_W = 16;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_BODY   = 2'd0;
  localparam phase_t PH_FIRST  = 2'd1;
  localparam phase_t PH_SECOND = 2'd2;
  localparam phase_t PH_DONE   = 2'd3;

  // bit 4 set when the byte is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      hex_digit = 5'h00;
      if (c inside {[8'h30:8'h39]}) begin
        d = c - 8'h30;
        hex_digit = {1'b1, d[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        d = c - 8'h37;
        hex_digit = {1'b1, d[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
        d = c - 8'h57;
        hex_digit = {1'b1, d[3:0]};
      end
    end
  endfunction

  function automatic logic is_space(logic [7:0] c);
    is_space = (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  // check pair read as a base-16 number and compared with the sum; the first character may also be a space, '+' or '-'
  function automatic logic pair_match(logic [7:0] c1, logic [7:0] c2, logic [7:0] sum);
    logic [4:0] a;
    logic [4:0] b;
    begin
      a = hex_digit(c1);
      b = hex_digit(c2);
      if (!b[4]) begin
        pair_match = 1'b0;
      end else if (a[4]) begin
        pair_match = ({a[3:0], b[3:0]} == sum);
      end else if (is_space(c1) || c1 == CH_PLUS) begin
        pair_match = ({4'h0, b[3:0]} == sum);
      end else if (c1 == CH_MINUS) begin
        pair_match = (b[3:0] == 4'h0) && (sum == 8'h00);
      end else begin
        pair_match = 1'b0;
      end
    end
  endfunction

endpackage

// File: design/nmea_checksum_checker.sv
// Checks the checksum of NMEA 0183 sentences streamed in one byte per request, with
// tlast on the final byte. Every byte before the first '*' except '$' is XORed; the two
// bytes after the star are parsed as base 16 and compared. One result request comes out per
// sentence, once its last byte has passed the input register and the result register. The block
// takes one byte every cycle; a stalled output holds it back only once both the input
// register and the result register are full. Reset clears all sentence state.
module nmea_checksum_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [nmea_cc_pkg::IN_W-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // end_of_line
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [nmea_cc_pkg::OUT_W-1:0] m_axis_tdata   // [0] checksum_ok,
                                                       // [8:1] computed_checksum, [15:9] zero
);
  import nmea_cc_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic       dollar_seen, dollar_seen_next;
  logic [7:0] running_xor, running_xor_next;
  phase_t     check_phase, check_phase_next;
  logic [7:0] first_check_char, first_check_char_next;
  logic       check_match, check_match_next;

  logic       out_valid;
  logic       out_ok;
  logic [7:0] out_sum;

  logic advance;
  logic work;

  assign advance       = !out_valid || m_axis_tready;
  assign work          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_comb begin
    dollar_seen_next      = dollar_seen || (in_byte == CH_DOLLAR);
    running_xor_next      = running_xor;
    check_phase_next      = check_phase;
    first_check_char_next = first_check_char;
    check_match_next      = check_match;
    case (check_phase)
      PH_BODY: begin
        if (in_byte == CH_STAR) begin
          check_phase_next = PH_FIRST;
        end else if (in_byte != CH_DOLLAR) begin
          running_xor_next = running_xor ^ in_byte;
        end
      end
      PH_FIRST: begin
        first_check_char_next = in_byte;
        check_phase_next      = PH_SECOND;
      end
      PH_SECOND: begin
        check_match_next = pair_match(first_check_char, in_byte, running_xor);
        check_phase_next = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dollar_seen      <= 1'b0;
      running_xor      <= 8'h00;
      check_phase      <= PH_BODY;
      first_check_char <= 8'h00;
      check_match      <= 1'b0;
    end else if (work) begin
      if (in_last) begin
        dollar_seen      <= 1'b0;
        running_xor      <= 8'h00;
        check_phase      <= PH_BODY;
        first_check_char <= 8'h00;
        check_match      <= 1'b0;
      end else begin
        dollar_seen      <= dollar_seen_next;
        running_xor      <= running_xor_next;
        check_phase      <= check_phase_next;
        first_check_char <= first_check_char_next;
        check_match      <= check_match_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= work && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (work && in_last) begin
      out_ok  <= dollar_seen_next && (check_phase_next == PH_DONE) && check_match_next;
      out_sum <= running_xor_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_sum, out_ok};

endmodule

// File: design/nmea_cc_checker.sv
`include "assert_macros.svh"

module nmea_cc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // no result right after reset
  `ASSERT_NEXT_RST(a_rst_quiet, clk, rst, !m_axis_tvalid)

  // padding above the sum stays zero
  `ASSERT_SAME(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[15:9] == 7'b0)

  // a fresh result follows a final byte taken in and passed through the input register
  `ASSERT_SAME(a_result_source, clk, rst, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))

endmodule

bind nmea_checksum_checker nmea_cc_checker u_nmea_cc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
